// ===== rtl/core/jsem_pkg.sv =====
// Shared types, character codes and helpers for the JSON escape/minify block.
`timescale 1ns / 1ps

package jsem_pkg;

    localparam int CP_W = 21;

    localparam logic [7:0] CHR_QUOTE  = 8'h22;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_U      = 8'h75;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_SPACE  = 8'h20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       stream_end;
        logic       unterminated;
    } t_out;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_ESC,
        KIND_MARK
    } t_kind;

    // One input word's worth of output, expanded later one result at a time
    typedef struct packed {
        t_kind           kind;
        logic [CP_W-1:0] value;
        logic [3:0]      cnt;
        logic            last;
        logic            unterm;
    } t_desc;

    // backslash, 'u' and 4..6 hex digits
    function automatic logic [3:0] esc_count(input logic [CP_W-1:0] cp);
        logic [3:0] c;
        if (cp > 21'h0FFFFF) begin
            c = 4'd8;
        end else if (cp > 21'h00FFFF) begin
            c = 4'd7;
        end else begin
            c = 4'd6;
        end
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h57 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/jsem_decode.sv =====
// Byte classifier: string/UTF-8 state and per-word output descriptor.
`timescale 1ns / 1ps

module jsem_decode (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  jsem_pkg::t_in  i_item,
    input  logic           i_minify,
    output jsem_pkg::t_desc o_desc,
    output logic           o_has
);

    logic                      r_inside, n_inside;
    logic [1:0]                r_pend, n_pend;
    logic [jsem_pkg::CP_W-1:0] r_acc, n_acc;
    logic [jsem_pkg::CP_W-1:0] acc_next;
    logic [7:0]                b;
    logic                      ws;
    jsem_pkg::t_desc           d;
    logic                      has;

    assign b        = i_item.in_byte;
    assign acc_next = {r_acc[jsem_pkg::CP_W-7:0], b[5:0]};
    assign ws       = (b == jsem_pkg::CHR_TAB) || (b == jsem_pkg::CHR_LF) ||
                      (b == jsem_pkg::CHR_CR) || (b == jsem_pkg::CHR_SPACE);

    always_comb begin
        n_inside = r_inside;
        n_pend   = r_pend;
        n_acc    = r_acc;
        has      = 1'b0;
        d.kind   = jsem_pkg::KIND_BYTE;
        d.value  = {{(jsem_pkg::CP_W-8){1'b0}}, b};
        d.cnt    = 4'd1;
        d.last   = i_item.in_last;
        d.unterm = 1'b0;

        if (b == jsem_pkg::CHR_QUOTE) begin
            // a quote always passes and drops any partial sequence
            n_pend   = 2'd0;
            n_acc    = '0;
            n_inside = ~r_inside;
            has      = 1'b1;
        end else if (!r_inside) begin
            has = !(ws && i_minify);
        end else if (r_pend != 2'd0) begin
            n_pend = r_pend - 2'd1;
            if (r_pend == 2'd1) begin
                has     = 1'b1;
                d.kind  = jsem_pkg::KIND_ESC;
                d.value = acc_next;
                d.cnt   = jsem_pkg::esc_count(acc_next);
                n_acc   = '0;
            end else begin
                n_acc = acc_next;
            end
        end else if (b[7:5] == 3'b110) begin
            n_acc  = {{(jsem_pkg::CP_W-5){1'b0}}, b[4:0]};
            n_pend = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            n_acc  = {{(jsem_pkg::CP_W-4){1'b0}}, b[3:0]};
            n_pend = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            n_acc  = {{(jsem_pkg::CP_W-3){1'b0}}, b[2:0]};
            n_pend = 2'd3;
        end else begin
            // plain or stray byte inside a string: escape by byte value
            has     = 1'b1;
            d.kind  = jsem_pkg::KIND_ESC;
            d.cnt   = jsem_pkg::esc_count(d.value);
        end

        if (i_item.in_last) begin
            d.unterm = n_inside;
            if (!has) begin
                has     = 1'b1;
                d.kind  = jsem_pkg::KIND_MARK;
                d.value = '0;
                d.cnt   = 4'd1;
            end
            n_inside = 1'b0;
            n_pend   = 2'd0;
            n_acc    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_pend   <= 2'd0;
            r_acc    <= '0;
        end else if (i_take) begin
            r_inside <= n_inside;
            r_pend   <= n_pend;
            r_acc    <= n_acc;
        end
    end

    assign o_desc = d;
    assign o_has  = has;

endmodule

// ===== rtl/core/jsem_emit.sv =====
// Descriptor register and result serializer feeding the output register.
`timescale 1ns / 1ps

module jsem_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  jsem_pkg::t_desc i_desc,
    output logic            o_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output jsem_pkg::t_out  o_out_data
);

    logic            r_desc_valid;
    jsem_pkg::t_desc r_desc;
    logic [2:0]      r_idx;
    logic            r_out_valid;
    jsem_pkg::t_out  r_out;

    logic            out_load;
    logic            at_end;
    logic            desc_done;
    logic [3:0]      sel;
    logic [3:0]      nib;
    jsem_pkg::t_out  n_out;

    assign out_load  = r_desc_valid && (!r_out_valid || i_out_ready);
    assign at_end    = ({1'b0, r_idx} == (r_desc.cnt - 4'd1));
    assign desc_done = out_load && at_end;
    assign o_ready   = !r_desc_valid || desc_done;

    // hex digits go out most significant first
    assign sel = r_desc.cnt - 4'd1 - {1'b0, r_idx};

    always_comb begin
        case (sel[2:0])
            3'd0:    nib = r_desc.value[3:0];
            3'd1:    nib = r_desc.value[7:4];
            3'd2:    nib = r_desc.value[11:8];
            3'd3:    nib = r_desc.value[15:12];
            3'd4:    nib = r_desc.value[19:16];
            3'd5:    nib = {3'd0, r_desc.value[20]};
            default: nib = 4'd0;
        endcase
    end

    always_comb begin
        n_out.has_byte     = 1'b1;
        n_out.out_byte     = r_desc.value[7:0];
        unique case (r_desc.kind)
            jsem_pkg::KIND_ESC: begin
                if (r_idx == 3'd0) begin
                    n_out.out_byte = jsem_pkg::CHR_BSLASH;
                end else if (r_idx == 3'd1) begin
                    n_out.out_byte = jsem_pkg::CHR_U;
                end else begin
                    n_out.out_byte = jsem_pkg::hex_char(nib);
                end
            end
            jsem_pkg::KIND_MARK: begin
                n_out.has_byte = 1'b0;
                n_out.out_byte = 8'd0;
            end
            default: begin
                n_out.out_byte = r_desc.value[7:0];
            end
        endcase
        n_out.run_last     = at_end;
        n_out.stream_end   = at_end && r_desc.last;
        n_out.unterminated = at_end && r_desc.last && r_desc.unterm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc_valid <= 1'b0;
            r_idx        <= 3'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_load) begin
                r_desc_valid <= 1'b1;
                r_idx        <= 3'd0;
            end else if (desc_done) begin
                r_desc_valid <= 1'b0;
            end else if (out_load) begin
                r_idx <= r_idx + 3'd1;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_desc <= i_desc;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/json_string_escape_minify.sv =====
// Top level of the JSON string escaper and minifier.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one text byte per
//   word with a final-byte flag. Output channel (o_out_valid / i_out_ready /
//   o_out_data) gives one character per word with run/stream marks.
//   i_cfg_we / i_cfg_data write minify_enable (reset 1); write only when idle.
// An accepted word passes the descriptor register, then the output register.
// Throughput: one result word per cycle without stalls, set by the single
//   output register. A word yields 1 result for a pass-through byte, 6 to 8 for
//   a \u escape, 0 for dropped whitespace or a held lead/continuation byte
//   (those are taken every cycle while input ready is high). A decoded word
//   waits in the descriptor register while the serializer walks it, so the next
//   word is accepted in the cycle the last result of the current one is loaded.
// Reset (synchronous, active low) clears string/UTF-8 state, both stages and
//   sets minify on. A word with in_last also returns state to reset after it.
// When the receiver stalls the output register holds, the serializer stops
//   and input ready drops once the descriptor register is occupied.

module json_string_escape_minify (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  jsem_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output jsem_pkg::t_out o_out_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_data
);

    logic            r_minify;
    logic            take;
    logic            has;
    logic            ready;
    jsem_pkg::t_desc desc;

    assign take       = i_in_valid && ready;
    assign o_in_ready = ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minify <= 1'b1;
        end else if (i_cfg_we) begin
            r_minify <= i_cfg_data;
        end
    end

    jsem_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_item   (i_in_data),
        .i_minify (r_minify),
        .o_desc   (desc),
        .o_has    (has)
    );

    jsem_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take && has),
        .i_desc      (desc),
        .o_ready     (ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/core/jsem_checker.sv =====
// Port-level checks for the JSON escaper, bound to the top level.
`timescale 1ns / 1ps

module jsem_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input jsem_pkg::t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");

    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.has_byte |->
            o_out_data.run_last && o_out_data.stream_end && o_out_data.out_byte == 8'd0)
        else $error("end-only marker malformed");

    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.stream_end |-> o_out_data.run_last)
        else $error("stream end not at end of run");

    a_unterm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.unterminated |-> o_out_data.stream_end)
        else $error("unterminated flag off the final word");

endmodule

bind json_string_escape_minify jsem_checker u_jsem_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the JSON string escaper and minifier.
`timescale 1ns / 1ps

module testbench;

    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_BYTES   = 30;

    localparam logic [7:0]  CHR_ZERO  = 8'h30;
    localparam logic [7:0]  CHR_A_LOW = 8'h61;
    localparam logic [7:0]  CHR_BRACE = 8'h7B;
    localparam logic [31:0] WS_SET    = {jsem_pkg::CHR_TAB, jsem_pkg::CHR_LF,
                                         jsem_pkg::CHR_CR, jsem_pkg::CHR_SPACE};

    // UTF-8 lead and continuation byte prefixes
    localparam logic [2:0] LEAD2 = 3'b110;
    localparam logic [3:0] LEAD3 = 4'b1110;
    localparam logic [4:0] LEAD4 = 5'b11110;
    localparam logic [1:0] CONT  = 2'b10;

    logic i_clk;
    logic i_rst_n  = 1'b0;
    logic in_valid = 1'b0;
    jsem_pkg::t_in  in_data  = '0;
    logic out_ready = 1'b0;
    logic cfg_we   = 1'b0;
    logic cfg_data = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    jsem_pkg::t_out o_out_data;

    json_string_escape_minify u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    jsem_pkg::t_in  text_bytes[$];
    jsem_pkg::t_out expected_chars[$];
    int   queued_bytes = 0;
    int   bad_words    = 0;
    int   burst_left   = 0;
    int   gap_left     = 0;
    int   run_left     = 0;
    int   stall_left   = 0;
    int   idle_cycles  = 0;

    // escaper state as the block should hold it
    logic        minify_m = 1'b1;
    logic        in_str_m = 1'b0;
    logic [1:0]  pend_m   = '0;
    logic [20:0] acc_m    = '0;

    task automatic report(input string fld, input logic [7:0] got, input logic [7:0] want);
        $display("ERROR @%0t: %s got %0h want %0h", $time, fld, got, want);
        bad_words++;
    endtask

    function automatic void push_char(input logic [7:0] c);
        jsem_pkg::t_out r;
        r = '0;
        r.out_byte = c;
        r.has_byte = 1'b1;
        expected_chars.push_back(r);
    endfunction

    function automatic void push_escape(input logic [20:0] cp);
        int ndig;
        logic [3:0] nib;
        ndig = (cp > 21'h0FFFFF) ? 6 : (cp > 21'h00FFFF) ? 5 : 4;
        push_char(jsem_pkg::CHR_BSLASH);
        push_char(jsem_pkg::CHR_U);
        for (int k = ndig - 1; k >= 0; k--) begin
            nib = 4'(cp >> (4 * k));
            push_char((nib < 4'd10) ? CHR_ZERO + 8'(nib) : CHR_A_LOW + 8'(nib) - 8'd10);
        end
    endfunction

    function automatic void escape_word(input jsem_pkg::t_in w);
        int base;
        logic [7:0] b;
        logic ws;
        jsem_pkg::t_out r;
        base = expected_chars.size();
        b = w.in_byte;
        ws = (b == jsem_pkg::CHR_TAB) || (b == jsem_pkg::CHR_LF) ||
             (b == jsem_pkg::CHR_CR) || (b == jsem_pkg::CHR_SPACE);
        if (b == jsem_pkg::CHR_QUOTE) begin
            pend_m = '0;
            acc_m = '0;
            in_str_m = ~in_str_m;
            push_char(b);
        end else if (!in_str_m) begin
            if (!(ws && minify_m)) begin
                push_char(b);
            end
        end else if (pend_m != 2'd0) begin
            acc_m = {acc_m[14:0], b[5:0]};
            pend_m = pend_m - 2'd1;
            if (pend_m == 2'd0) begin
                push_escape(acc_m);
                acc_m = '0;
            end
        end else if (b[7:5] == LEAD2) begin
            acc_m = {16'd0, b[4:0]};
            pend_m = 2'd1;
        end else if (b[7:4] == LEAD3) begin
            acc_m = {17'd0, b[3:0]};
            pend_m = 2'd2;
        end else if (b[7:3] == LEAD4) begin
            acc_m = {18'd0, b[2:0]};
            pend_m = 2'd3;
        end else begin
            push_escape({13'd0, b});
        end
        if (w.in_last) begin
            // nothing produced: a bare end marker closes the text
            if (expected_chars.size() == base) begin
                expected_chars.push_back('0);
            end
            r = expected_chars.pop_back();
            r.stream_end = 1'b1;
            r.unterminated = in_str_m;
            expected_chars.push_back(r);
            in_str_m = 1'b0;
            pend_m = '0;
            acc_m = '0;
        end
        if (expected_chars.size() > base) begin
            r = expected_chars.pop_back();
            r.run_last = 1'b1;
            expected_chars.push_back(r);
        end
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic last = 1'b0);
        jsem_pkg::t_in w;
        w.in_byte = b;
        w.in_last = last;
        text_bytes.push_back(w);
        queued_bytes++;
    endtask

    task automatic add_cont(input int n);
        logic [7:0] b;
        repeat (n) begin
            b = {CONT, 6'($urandom)};
            // now and then a malformed continuation
            if ($urandom_range(0, 9) == 0) begin
                b = 8'($urandom);
                if (b == jsem_pkg::CHR_QUOTE) b = 8'h7F;
            end
            add_byte(b);
        end
    endtask

    task automatic add_utf8();
        logic [7:0] b;
        case ($urandom_range(0, 4))
            0: begin
                b = 8'($urandom_range(0, 127));
                if (b == jsem_pkg::CHR_QUOTE) b = jsem_pkg::CHR_BSLASH;
                add_byte(b);
            end
            1: begin
                add_byte({LEAD2, 5'($urandom)});
                add_cont(1);
            end
            2: begin
                add_byte({LEAD3, 4'($urandom)});
                add_cont(2);
            end
            3: begin
                add_byte({LEAD4, 3'($urandom)});
                add_cont(3);
            end
            default: begin
                // stray continuation or never-valid byte
                if ($urandom_range(0, 1) == 0) begin
                    add_byte(8'($urandom_range(128, 191)));
                end else begin
                    add_byte(8'($urandom_range(248, 255)));
                end
            end
        endcase
    endtask

    task automatic gen_text();
        int ntok;
        int sel;
        logic [7:0] b;
        jsem_pkg::t_in w;
        ntok = $urandom_range(1, 6);
        for (int t = 0; t < ntok; t++) begin
            sel = $urandom_range(0, 11);
            if (sel < 3) begin
                add_byte(WS_SET[8 * $urandom_range(0, 3) +: 8]);
            end else if (sel < 5) begin
                b = 8'($urandom_range(33, 126));
                add_byte((b == jsem_pkg::CHR_QUOTE) ? CHR_BRACE : b);
            end else if (sel < 10) begin
                add_byte(jsem_pkg::CHR_QUOTE);
                repeat ($urandom_range(0, 4)) add_utf8();
                if ($urandom_range(0, 7) != 0) add_byte(jsem_pkg::CHR_QUOTE);
            end else if (sel == 10) begin
                add_byte(8'($urandom));
            end else begin
                // string cut off by its closing quote mid-sequence
                add_byte(jsem_pkg::CHR_QUOTE);
                add_byte({LEAD4, 3'($urandom)});
                if ($urandom_range(0, 1) == 1) add_byte({CONT, 6'($urandom)});
                add_byte(jsem_pkg::CHR_QUOTE);
            end
        end
        w = text_bytes.pop_back();
        w.in_last = 1'b1;
        text_bytes.push_back(w);
    endtask

    task automatic fill_texts(input int count);
        int target;
        target = queued_bytes + count;
        while (queued_bytes < target) gen_text();
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (text_bytes.size() != 0 || in_valid || expected_chars.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic v);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        minify_m = v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) escape_word(in_data);
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (text_bytes.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data <= text_bytes.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each word, stalls on its own pattern
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                if (expected_chars.size() == 0) begin
                    report("unexpected word", o_out_data.out_byte, 8'h00);
                end else begin
                    jsem_pkg::t_out e;
                    e = expected_chars.pop_front();
                    if (o_out_data.out_byte != e.out_byte)
                        report("out_byte", o_out_data.out_byte, e.out_byte);
                    if (o_out_data.has_byte != e.has_byte)
                        report("has_byte", 8'(o_out_data.has_byte), 8'(e.has_byte));
                    if (o_out_data.run_last != e.run_last)
                        report("run_last", 8'(o_out_data.run_last), 8'(e.run_last));
                    if (o_out_data.stream_end != e.stream_end)
                        report("stream_end", 8'(o_out_data.stream_end), 8'(e.stream_end));
                    if (o_out_data.unterminated != e.unterminated)
                        report("unterminated", 8'(o_out_data.unterminated),
                               8'(e.unterminated));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(0, 6);
                    stall_left = $urandom_range(1, 8);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        // minify on from reset: dropped blank, every escape width, cut sequence,
        // end-only marker on a dropped final byte
        add_byte(jsem_pkg::CHR_SPACE);
        add_byte(8'h41);
        add_byte(jsem_pkg::CHR_QUOTE);
        add_byte(8'h00);
        add_byte(8'h80);
        add_byte(8'hFF);
        add_byte(8'hC3); add_byte(8'hA9);
        add_byte(8'hE2); add_byte(8'h82); add_byte(8'hAC);
        add_byte(8'hF0); add_byte(8'h9F); add_byte(8'h98); add_byte(8'h80);
        add_byte(8'hF7); add_byte(8'hBF); add_byte(8'hBF); add_byte(8'hBF);
        add_byte(8'hC3); add_byte(jsem_pkg::CHR_QUOTE);
        add_byte(jsem_pkg::CHR_LF, 1'b1);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait_idle();
        cfg_write(1'b0);
        // blank kept, text ends inside a string
        add_byte(jsem_pkg::CHR_SPACE);
        add_byte(jsem_pkg::CHR_QUOTE);
        add_byte(8'h61, 1'b1);

        for (int p = 0; p < 4; p++) begin
            wait_idle();
            cfg_write(p[0] ? 1'b0 : 1'b1);
            fill_texts(PHASE_BYTES);
        end
        wait_idle();

        if (bad_words == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/jsem_pkg.sv
rtl/core/jsem_decode.sv
rtl/core/jsem_emit.sv
rtl/core/json_string_escape_minify.sv
rtl/core/jsem_checker.sv
sim/testbench.sv
